// ===== rtl/core/fpa_pkg.sv =====
// Shared types and codes for the fixed-point ALU.
// No dependencies.
package fpa_pkg;

    localparam int MAX_W = 32;

    // operation codes
    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_GT       = 4'd4;
    localparam logic [3:0] OP_LT       = 4'd5;
    localparam logic [3:0] OP_GE       = 4'd6;
    localparam logic [3:0] OP_LE       = 4'd7;
    localparam logic [3:0] OP_EQ       = 4'd8;
    localparam logic [3:0] OP_NE       = 4'd9;
    localparam logic [3:0] OP_TO_INT   = 4'd10;
    localparam logic [3:0] OP_FROM_INT = 4'd11;

    typedef logic [1:0] t_kind;
    localparam t_kind K_SIMPLE = 2'd0;  // result already final
    localparam t_kind K_MUL    = 2'd1;
    localparam t_kind K_DIV    = 2'd2;

    // classified request, front to back
    typedef struct packed {
        t_kind             kind;
        logic              neg;
        logic              dbz;
        logic              cmp;
        logic [MAX_W-1:0]  res;
        logic [MAX_W-1:0]  mag_a;
        logic [MAX_W-1:0]  mag_b;
    } t_item;

endpackage

// ===== rtl/core/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU.
// Depends on fpa_pkg, fpa_front, fpa_queue, fpa_back.
//
// Usage:
//  - Requests enter on the s_axis channel: tuser carries the operation code,
//    tdata carries operand_a (bits 31:0) and operand_b (bits 63:32).
//  - Results leave on the m_axis channel: tdata carries result (31:0),
//    compare_true (32), divide_by_zero (33), saturated (34), zeros above.
//  - Exactly one result per request, in request order.
//  - Throughput: one request per cycle, sustained while m_axis_tready is high.
//  - The delay from acceptance to the result being shown is the same for
//    every operation; the divider, one quotient bit per stage, sets the
//    pipeline depth.
//  - The front decodes and finishes add/sub/compare/convert, then a
//    two-entry queue feeds the back pipeline (multiplier, divider, rounding).
//  - When m_axis_tready is low while a result is shown, the whole back pipeline
//    holds; the queue then fills and s_axis_tready drops, with nothing lost.
//  - Synchronous active-low reset empties the queue and pipeline; the block
//    keeps no other state.
module fixed_point_alu #(
    parameter int FRACTION_BITS = 8,
    parameter int WORD_BITS     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
    input  logic [3:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result, compare_true, divide_by_zero,
                                        // saturated, zero pad
);
    import fpa_pkg::*;

    t_item       front_item, q_item;
    logic        q_full, q_valid, back_ready;
    logic [31:0] res;
    logic        cmp, dbz, sat;

    fpa_front #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_op   (s_axis_tuser),
        .i_a    (s_axis_tdata[31:0]),
        .i_b    (s_axis_tdata[63:32]),
        .o_item (front_item)
    );

    assign s_axis_tready = !q_full;

    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (back_ready),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fpa_back #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_ready  (back_ready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res),
        .o_cmp    (cmp),
        .o_dbz    (dbz),
        .o_sat    (sat)
    );

    assign m_axis_tdata = {5'd0, sat, dbz, cmp, res};

endmodule

// ===== rtl/core/fpa_front.sv =====
// Front end: decodes a request and finishes all but multiply and nonzero divide.
// Depends on fpa_pkg.
module fpa_front #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic [3:0]          i_op,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    output fpa_pkg::t_item      o_item
);
    import fpa_pkg::*;

    localparam int SH = 32 - WORD_BITS;

    function automatic logic [31:0] sx(input logic [31:0] v);
        return 32'($signed(v << SH) >>> SH);
    endfunction

    logic [31:0] a32, b32;
    logic        lt, eq;

    assign a32 = sx(i_a);
    assign b32 = sx(i_b);
    assign lt  = $signed(a32) < $signed(b32);
    assign eq  = a32 == b32;

    always_comb begin
        o_item       = '0;
        o_item.kind  = K_SIMPLE;
        o_item.neg   = a32[31] ^ b32[31];
        o_item.mag_a = a32[31] ? 32'(32'd0 - a32) : a32;
        o_item.mag_b = b32[31] ? 32'(32'd0 - b32) : b32;
        case (i_op)
            OP_ADD:      o_item.res = sx(a32 + b32);
            OP_SUB:      o_item.res = sx(a32 - b32);
            OP_MUL:      o_item.kind = K_MUL;
            OP_DIV: begin
                if (b32 == '0) begin
                    o_item.dbz = 1'b1;
                end else begin
                    o_item.kind = K_DIV;
                end
            end
            OP_GT:       o_item.cmp = !lt && !eq;
            OP_LT:       o_item.cmp = lt;
            OP_GE:       o_item.cmp = !lt;
            OP_LE:       o_item.cmp = lt || eq;
            OP_EQ:       o_item.cmp = eq;
            OP_NE:       o_item.cmp = !eq;
            OP_TO_INT:   o_item.res = 32'($signed(a32) >>> FRACTION_BITS);
            OP_FROM_INT: o_item.res = sx(a32 << FRACTION_BITS);
            default:     o_item.res = '0;
        endcase
    end

endmodule

// ===== rtl/core/fpa_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on fpa_pkg.
module fpa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fpa_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fpa_pkg::t_item o_item
);
    import fpa_pkg::*;

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= 2'(r_cnt + 2'(do_push) - 2'(do_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ===== rtl/core/fpa_back.sv =====
// Back end: multiplier, bit-per-stage divider, rounding, clamp, output register.
// Depends on fpa_pkg.
module fpa_back #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fpa_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_result,
    output logic           o_cmp,
    output logic           o_dbz,
    output logic           o_sat
);
    import fpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int DS = W + F;       // divider stages
    localparam int L  = DS;          // last stage index
    localparam int QW = 2 * W + 1;
    localparam logic [31:0] WMAX32 = 32'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [31:0] WMIN32 = ~WMAX32;

    logic          r_v    [DS+1];
    t_kind         r_k    [DS+1];
    logic          r_neg  [DS+1];
    logic          r_dbz  [DS+1];
    logic          r_cmp  [DS+1];
    logic [31:0]   r_res  [DS+1];
    logic [2*W-1:0] r_prod [DS+1];
    logic [DS-1:0] r_num  [DS+1];
    logic [W-1:0]  r_rem  [DS+1];
    logic [W-1:0]  r_den  [DS+1];

    logic [W:0]    c_rs   [DS+1];
    logic          c_ge   [DS+1];

    logic          adv;
    logic          r_ov;
    logic [31:0]   r_ores;
    logic          r_ocmp, r_odbz, r_osat;

    logic [QW-1:0] c_mr, c_q, LIM;
    logic          rnd, sat;
    logic [31:0]   fin;

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;

    always_comb begin
        for (int i = 0; i <= DS; i++) begin
            c_rs[i] = '0;
            c_ge[i] = 1'b0;
        end
        for (int i = 1; i <= DS; i++) begin
            c_rs[i] = {r_rem[i-1], r_num[i-1][DS-1]};
            c_ge[i] = c_rs[i] >= {1'b0, r_den[i-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DS; i++) r_v[i] <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i <= DS; i++) r_v[i] <= r_v[i-1];
            r_ov <= r_v[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_k[0]    <= i_item.kind;
            r_neg[0]  <= i_item.neg;
            r_dbz[0]  <= i_item.dbz;
            r_cmp[0]  <= i_item.cmp;
            r_res[0]  <= i_item.res;
            r_prod[0] <= i_item.mag_a[W-1:0] * i_item.mag_b[W-1:0];
            r_num[0]  <= {i_item.mag_a[W-1:0], {F{1'b0}}};
            r_rem[0]  <= '0;
            r_den[0]  <= i_item.mag_b[W-1:0];
            for (int i = 1; i <= DS; i++) begin
                r_k[i]    <= r_k[i-1];
                r_neg[i]  <= r_neg[i-1];
                r_dbz[i]  <= r_dbz[i-1];
                r_cmp[i]  <= r_cmp[i-1];
                r_res[i]  <= r_res[i-1];
                r_prod[i] <= r_prod[i-1];
                r_den[i]  <= r_den[i-1];
                r_num[i]  <= {r_num[i-1][DS-2:0], c_ge[i]};
                r_rem[i]  <= c_ge[i] ? W'(c_rs[i] - {1'b0, r_den[i-1]}) : c_rs[i][W-1:0];
            end
            r_ores <= fin;
            r_ocmp <= r_cmp[L];
            r_odbz <= r_dbz[L];
            r_osat <= sat;
        end
    end

    // round half away from zero on the magnitude, then clamp and apply sign
    always_comb begin
        LIM  = QW'(1) << (W - 1);
        c_mr = {1'b0, r_prod[L]} + (QW'(1) << (F - 1));
        rnd  = {r_rem[L], 1'b0} >= {1'b0, r_den[L]};
        c_q  = (r_k[L] == K_MUL) ? (c_mr >> F) : (QW'(r_num[L]) + QW'(rnd));
        sat  = 1'b0;
        fin  = r_res[L];
        if (r_k[L] == K_MUL || r_k[L] == K_DIV) begin
            if (r_neg[L]) begin
                sat = c_q > LIM;
                fin = sat ? WMIN32 : 32'(32'd0 - c_q[31:0]);
            end else begin
                sat = c_q > (LIM - QW'(1));
                fin = sat ? WMAX32 : c_q[31:0];
            end
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_ores;
    assign o_cmp    = r_ocmp;
    assign o_dbz    = r_odbz;
    assign o_sat    = r_osat;

endmodule

// ===== sim/fixed_point_alu_test.sv =====
// Testbench for the fixed-point ALU: directed table then random requests,
// each result checked against an in-bench predictor. Depends on fpa_pkg and
// fixed_point_alu.
module fixed_point_alu_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    localparam int FRAC     = 8;
    localparam int N_RANDOM = 1880;
    localparam int LATENCY  = 32 + FRAC + 3;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        dbz;
        logic        sat;
    } alu_result_t;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        bit          typed;     // expectation typed in below
        alu_result_t want;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // operand_a, operand_b
    logic [3:0]  s_axis_tuser;     // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // result, compare_true, divide_by_zero, saturated

    alu_result_t pending_results[$];
    int          n_errors;
    int          n_checked;
    longint      n_cycles;

    fixed_point_alu u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Clamp a magnitude with a sign into the 32-bit word range.
    function automatic logic [31:0] clamp_word(logic [63:0] q, bit neg, output bit sat);
        sat = 1'b0;
        if (neg) begin
            if (q > 64'h8000_0000) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic alu_result_t alu_predict(logic [3:0] op, logic [31:0] a_raw,
                                                logic [31:0] b_raw);
        alu_result_t r;
        logic signed [31:0] a, b;
        logic [63:0] ma, mb, p, q, num, rem;
        bit neg, sat;
        a   = a_raw;
        b   = b_raw;
        ma  = a[31] ? 64'(-$signed(64'(a))) : 64'(a);
        mb  = b[31] ? 64'(-$signed(64'(b))) : 64'(b);
        neg = a[31] ^ b[31];
        r   = '0;
        sat = 1'b0;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: begin
                p = ma * mb;
                q = (p + (64'd1 << (FRAC - 1))) >> FRAC;
                r.value = clamp_word(q, neg, sat);
                r.sat = sat;
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dbz = 1'b1;
                end else begin
                    num = ma << FRAC;
                    q   = num / mb;
                    rem = num % mb;
                    if (2 * rem >= mb) q++;
                    r.value = clamp_word(q, neg, sat);
                    r.sat = sat;
                end
            end
            OP_GT:       r.cmp = a > b;
            OP_LT:       r.cmp = a < b;
            OP_GE:       r.cmp = a >= b;
            OP_LE:       r.cmp = a <= b;
            OP_EQ:       r.cmp = a == b;
            OP_NE:       r.cmp = a != b;
            OP_TO_INT:   r.value = a >>> FRAC;
            OP_FROM_INT: r.value = a << FRAC;
            default:     r = '0;
        endcase
        return r;
    endfunction

    // Mostly no gap, often a short one, occasionally a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return 32'($signed($urandom_range(0, 2048)) - 1024);
            2:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            3:       return $urandom_range(0, 3) == 0 ? 32'd0 : 32'd256;
            default: return $urandom();
        endcase
    endfunction

    // Directed rows: typed expectations only where obvious, else predictor.
    stim_row_t directed_rows[] = '{
        '{OP_ADD, 32'h7FFF_FFFF, 32'h1, 1, '{32'h8000_0000, 0, 0, 0}},
        '{OP_SUB, 32'h8000_0000, 32'h1, 1, '{32'h7FFF_FFFF, 0, 0, 0}},
        '{OP_MUL, 32'h0000_0100, 32'h0000_0100, 1, '{32'h0000_0100, 0, 0, 0}},
        '{OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, '{32'h7FFF_FFFF, 0, 0, 1}},
        '{OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'h8000_0000, 0, 0, 1}},
        '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 1, '{32'h7FFF_FFFF, 0, 0, 1}},
        '{OP_MUL, 32'h0000_0001, 32'h0000_0080, 0, '0},
        '{OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 0, '0},
        '{OP_DIV, 32'h1234_5678, 32'h0, 1, '{32'h0, 0, 1, 0}},
        '{OP_DIV, 32'h8000_0000, 32'h0, 1, '{32'h0, 0, 1, 0}},
        '{OP_DIV, 32'h7FFF_FFFF, 32'h1, 1, '{32'h7FFF_FFFF, 0, 0, 1}},
        '{OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1, '{32'h7FFF_FFFF, 0, 0, 1}},
        '{OP_DIV, 32'h0000_0100, 32'h0000_0300, 0, '0},
        '{OP_DIV, 32'hFFFF_FF00, 32'h0000_0200, 0, '0},
        '{OP_GT, 32'h7FFF_FFFF, 32'h8000_0000, 1, '{32'h0, 1, 0, 0}},
        '{OP_LT, 32'h7FFF_FFFF, 32'h8000_0000, 1, '{32'h0, 0, 0, 0}},
        '{OP_GE, 32'h5, 32'h5, 1, '{32'h0, 1, 0, 0}},
        '{OP_LE, 32'h8000_0000, 32'h8000_0000, 1, '{32'h0, 1, 0, 0}},
        '{OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{32'h0, 1, 0, 0}},
        '{OP_NE, 32'h0, 32'h0, 1, '{32'h0, 0, 0, 0}},
        // to_int rounds toward minus infinity
        '{OP_TO_INT, 32'hFFFF_FFFF, 32'h0, 1, '{32'hFFFF_FFFF, 0, 0, 0}},
        '{OP_TO_INT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, '{32'h007F_FFFF, 0, 0, 0}},
        // from_int wraps, never saturates
        '{OP_FROM_INT, 32'h7FFF_FFFF, 32'h0, 1, '{32'hFFFF_FF00, 0, 0, 0}},
        '{4'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{32'h0, 0, 0, 0}},
        '{4'd15, 32'h1234_5678, 32'h9ABC_DEF0, 1, '{32'h0, 0, 0, 0}}
    };

    // Present one request and hold it until accepted. tvalid stays high
    // after acceptance; it only drops when a gap follows.
    task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                bit typed, alu_result_t want);
        alu_result_t predicted;
        int          gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predicted = alu_predict(op, a, b);
        if (typed && predicted !== want) begin
            $error("typed expectation differs from predictor: op=%0d", op);
            n_errors++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Result side: random back-pressure and in-order checking.
    initial begin
        alu_result_t exp_r, got;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 199) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) < 70);
            end
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
                       m_axis_tdata[34]};
                if (pending_results.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    n_checked++;
                    if (got.value !== exp_r.value) begin
                        $error("result: expected %h, got %h", exp_r.value, got.value);
                        n_errors++;
                    end
                    if (got.cmp !== exp_r.cmp) begin
                        $error("compare_true: expected %b, got %b", exp_r.cmp, got.cmp);
                        n_errors++;
                    end
                    if (got.dbz !== exp_r.dbz) begin
                        $error("divide_by_zero: expected %b, got %b", exp_r.dbz, got.dbz);
                        n_errors++;
                    end
                    if (got.sat !== exp_r.sat) begin
                        $error("saturated: expected %b, got %b", exp_r.sat, got.sat);
                        n_errors++;
                    end
                    if (m_axis_tdata[39:35] !== 5'b0) begin
                        $error("pad bits: expected 0, got %b", m_axis_tdata[39:35]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog: cycle count from time zero.
    initial begin
        n_cycles = 0;
        forever begin
            @(posedge i_clk);
            n_cycles++;
            if (n_cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", n_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [3:0] op;
        n_errors      = 0;
        n_checked     = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                         directed_rows[i].typed, directed_rows[i].want);

        // Random: bias to legal ops, a few unused codes.
        for (int i = 0; i < N_RANDOM; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
            send_request(op, rand_operand(), rand_operand(), 0, '0);
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d results: all twelve operations, unused codes,", n_checked);
        $display("overflow, zero divisor and rounding edges under random stalls");
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
